>>> sv/b64s_pkg.sv
// ----------------------------------------------------------------------------
// b64s_pkg
// Shared types, character constants and the sextet-to-ASCII mapping for the
// streaming base64 encoder.
// ----------------------------------------------------------------------------
package b64s_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BPL_W   = 6;
  localparam int unsigned SEXT_W  = 6;
  localparam int unsigned GRP_N   = 5;   // four characters plus optional line feed
  localparam int unsigned IDX_W   = 3;

  localparam logic [BPL_W-1:0]  BPL_RESET = 6'd19;

  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'd65;  // 'A'
  localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'd97;  // 'a'
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'd48;  // '0'
  localparam logic [BYTE_W-1:0] CH_PLUS    = 8'd43;  // '+'
  localparam logic [BYTE_W-1:0] CH_SLASH   = 8'd47;  // '/'
  localparam logic [BYTE_W-1:0] CH_PAD     = 8'd61;  // '='
  localparam logic [BYTE_W-1:0] CH_LF      = 8'd10;

  localparam logic [IDX_W-1:0]  IDX_LAST_CHAR = 3'd3;
  localparam logic [IDX_W-1:0]  IDX_LF        = 3'd4;

  typedef logic [BYTE_W-1:0] char_t;

  // one finished group of output characters
  typedef struct packed {
    char_t [GRP_N-1:0] chars;
    logic              has_lf;
    logic              fin;
  } group_t;

  function automatic char_t b64_char(input logic [SEXT_W-1:0] v);
    char_t c;
    c = CH_SLASH;
    if (v < 6'd26) begin
      c = CH_UPPER_A + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CH_LOWER_A + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = CH_ZERO + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = CH_PLUS;
    end
    return c;
  endfunction

endpackage

>>> sv/b64s_in_if.sv
// ----------------------------------------------------------------------------
// b64s_in_if
// Raw byte request channel into the encoder.
// ----------------------------------------------------------------------------
interface b64s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

>>> sv/b64s_out_if.sv
// ----------------------------------------------------------------------------
// b64s_out_if
// Encoded character channel out of the encoder.
// ----------------------------------------------------------------------------
interface b64s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       stream_end;

  modport source (output valid, output out_char, output run_last, output stream_end,
                  input ready);
  modport sink   (input valid, input out_char, input run_last, input stream_end,
                  output ready);
endinterface

>>> sv/b64s_cfg_if.sv
// ----------------------------------------------------------------------------
// b64s_cfg_if
// Write channel for the line-length register.
// ----------------------------------------------------------------------------
interface b64s_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] blocks_per_line;

  modport source (output valid, output blocks_per_line, input ready);
  modport sink   (input valid, input blocks_per_line, output ready);
endinterface

>>> sv/b64s_grouper.sv
// ----------------------------------------------------------------------------
// b64s_grouper
// Holds pending bytes, forms a complete group on the third or final byte and
// keeps the per-line block count.
// ----------------------------------------------------------------------------
module b64s_grouper (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic [b64s_pkg::BYTE_W-1:0]  in_byte,
  input  logic                         final_byte,
  input  logic [b64s_pkg::BPL_W-1:0]   blocks_per_line,
  output logic                         grp_evt,
  output b64s_pkg::group_t             grp
);
  import b64s_pkg::*;

  logic [2*BYTE_W-1:0] held_r, held_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic [BPL_W-1:0]    count_r, count_nxt;
  logic [BPL_W-1:0]    count_inc;
  logic [BYTE_W-1:0]   b0, b1, b2;
  logic                two_plus, three;
  logic                lf;

  always_comb begin
    grp_evt   = (phase_r >= 2'd2) || final_byte;
    // byte count of the group: 1, 2 or 3
    three     = (phase_r >= 2'd2);
    two_plus  = (phase_r != 2'd0);

    b0 = two_plus ? held_r[2*BYTE_W-1:BYTE_W] : in_byte;
    b1 = three ? held_r[BYTE_W-1:0] : (two_plus ? in_byte : '0);
    b2 = three ? in_byte : '0;

    count_inc = count_r + 1'b1;
    lf        = (blocks_per_line != '0) && (count_inc == blocks_per_line);

    grp.chars[0] = b64_char(b0[7:2]);
    grp.chars[1] = b64_char({b0[1:0], b1[7:4]});
    grp.chars[2] = two_plus ? b64_char({b1[3:0], b2[7:6]}) : CH_PAD;
    grp.chars[3] = three ? b64_char(b2[5:0]) : CH_PAD;
    grp.chars[4] = CH_LF;
    grp.has_lf   = lf;
    grp.fin      = final_byte;

    held_nxt  = held_r;
    phase_nxt = phase_r;
    count_nxt = count_r;
    if (in_fire) begin
      if (grp_evt) begin
        held_nxt  = '0;
        phase_nxt = 2'd0;
        count_nxt = (lf || final_byte) ? '0 : count_inc;
      end else begin
        if (phase_r == 2'd0) begin
          held_nxt[2*BYTE_W-1:BYTE_W] = in_byte;
        end else begin
          held_nxt[BYTE_W-1:0] = in_byte;
        end
        phase_nxt = phase_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      phase_r <= '0;
      count_r <= '0;
    end else begin
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> sv/b64s_serializer.sv
// ----------------------------------------------------------------------------
// b64s_serializer
// Group register that hands out its characters one per cycle on the result
// channel while that channel is ready.
// ----------------------------------------------------------------------------
module b64s_serializer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  b64s_pkg::group_t    grp_in,
  output logic                slot_free,
  b64s_out_if.source          out_ch
);
  import b64s_pkg::*;

  group_t            grp_r, grp_nxt;
  logic              busy_r, busy_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              is_last;
  logic              out_fire;

  always_comb begin
    is_last   = grp_r.has_lf ? (idx_r == IDX_LF) : (idx_r == IDX_LAST_CHAR);
    out_fire  = busy_r && out_ch.ready;
    slot_free = !busy_r || (out_fire && is_last);

    out_ch.valid      = busy_r;
    out_ch.out_char   = grp_r.chars[idx_r];
    out_ch.run_last   = is_last;
    out_ch.stream_end = is_last && grp_r.fin;

    grp_nxt  = grp_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (out_fire) begin
      idx_nxt = idx_r + 1'b1;
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      grp_nxt  = grp_in;
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
    grp_r <= grp_nxt;
  end

endmodule

>>> sv/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder with optional line wrap.
// ----------------------------------------------------------------------------
// Takes one byte per request and emits standard-alphabet base64, one
// character per cycle while the output is ready. The first and second bytes
// of a group are taken straight away, even while an earlier group is still
// going out; the byte that completes a group waits only until the group
// register is free, which happens on the cycle its last character is taken.
// Throughput is set by the output port: a group of three bytes gives four
// characters, five when a line feed follows. A final byte pads a short group
// with '=' and clears the line count. blocks_per_line (reset 19, 0 = no wrap)
// may be written at any time the channel is quiet; cfg is always ready.
module base64_stream_encoder (
  input  logic        clk,
  input  logic        rst_n,
  b64s_in_if.sink     in_chan,
  b64s_out_if.source  out_chan,
  b64s_cfg_if.sink    cfg_chan
);
  import b64s_pkg::*;

  logic [BPL_W-1:0] bpl_r;
  logic             grp_evt;
  logic             slot_free;
  logic             in_fire;
  group_t           grp;

  // bytes that only get held never need the group register
  assign in_chan.ready = slot_free || !grp_evt;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpl_r <= BPL_RESET;
    end else if (cfg_chan.valid) begin
      bpl_r <= cfg_chan.blocks_per_line;
    end
  end

  b64s_grouper u_grouper (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_fire         (in_fire),
    .in_byte         (in_chan.in_byte),
    .final_byte      (in_chan.final_byte),
    .blocks_per_line (bpl_r),
    .grp_evt         (grp_evt),
    .grp             (grp)
  );

  b64s_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire && grp_evt),
    .grp_in    (grp),
    .slot_free (slot_free),
    .out_ch    (out_chan)
  );

endmodule

>>> tb/sv/tb_base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder
// Self-checking bench for the streaming base64 encoder with line wrap.
// ----------------------------------------------------------------------------
// Byte requests go in through the input channel. Each accepted byte is run
// through a behavioural encoder kept in the bench, and the characters it
// should produce are queued. Every character taken from the output channel
// is checked against the oldest queued one. The line length is changed only
// while the encoder is quiet. Directed streams cover the padding and
// line-feed corners. Random streams follow, under several sender and
// receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder;
  import b64s_pkg::*;

  typedef struct {
    char_t code;
    logic  run_last;
    logic  stream_end;
  } enc_char_t;

  localparam logic [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic clk;
  logic rst_n;

  b64s_in_if  in_bus ();
  b64s_out_if out_bus ();
  b64s_cfg_if cfg_bus ();

  base64_stream_encoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  // encoder state as the bench sees it
  logic [15:0]      held;
  logic [1:0]       held_cnt;
  logic [BPL_W-1:0] blk_cnt;
  logic [BPL_W-1:0] line_len;

  enc_char_t pending_chars[$];

  int send_idle_pct;
  int recv_stall_pct;
  int bytes_sent;
  int chars_checked;
  int line_feeds_seen;
  int settings_used;
  int mismatches;

  always #5 clk = ~clk;

  function automatic char_t sextet_char(input logic [5:0] v);
    return ALPHABET[8*(63-v) +: 8];
  endfunction

  task automatic encode_byte(input char_t b, input logic fin);
    char_t     b0, b1, b2;
    char_t     grp[5];
    int        nbytes;
    int        n;
    enc_char_t rec;
    if (held_cnt < 2'd2 && !fin) begin
      if (held_cnt == 2'd0) held = {b, 8'h00};
      else held[7:0] = b;
      held_cnt = held_cnt + 2'd1;
      return;
    end
    nbytes = int'(held_cnt) + 1;
    b0 = (nbytes == 1) ? b : held[15:8];
    b1 = (nbytes == 2) ? b : ((nbytes == 3) ? held[7:0] : 8'h00);
    b2 = (nbytes == 3) ? b : 8'h00;
    grp[0] = sextet_char(b0[7:2]);
    grp[1] = sextet_char({b0[1:0], b1[7:4]});
    if (nbytes > 1) begin
      grp[2] = sextet_char({b1[3:0], b2[7:6]});
      grp[3] = (nbytes > 2) ? sextet_char(b2[5:0]) : CH_PAD;
    end else begin
      grp[2] = CH_PAD;
      grp[3] = CH_PAD;
    end
    n = 4;
    blk_cnt = blk_cnt + 1'b1;
    // only an exact match breaks the line, so a lowered length waits for the wrap
    if (line_len != '0 && blk_cnt == line_len) begin
      grp[4] = CH_LF;
      n = 5;
      blk_cnt = '0;
    end
    for (int i = 0; i < n; i++) begin
      rec.code       = grp[i];
      rec.run_last   = (i == n - 1);
      rec.stream_end = (i == n - 1) && fin;
      pending_chars.push_back(rec);
    end
    if (fin) blk_cnt = '0;
    held     = '0;
    held_cnt = '0;
  endtask

  // one byte request, with random idle cycles ahead of it
  task automatic send_byte(input char_t b, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.in_byte    <= b;
    in_bus.final_byte <= fin;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    encode_byte(b, fin);
    bytes_sent++;
  endtask

  // stop sending and let every queued character drain out
  task automatic quiesce();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    // a byte that only gets held leaves nothing queued, so give it time to land
    repeat (8) @(posedge clk);
  endtask

  task automatic write_line_length(input logic [BPL_W-1:0] v);
    quiesce();
    @(negedge clk);
    cfg_bus.valid           <= 1'b1;
    cfg_bus.blocks_per_line <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    line_len = v;
    settings_used++;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_group(input char_t a, input char_t b, input char_t c, input logic fin);
    send_byte(a, 1'b0);
    send_byte(b, 1'b0);
    send_byte(c, fin);
  endtask

  // padding forms with the default line length of 19
  task automatic test_padding();
    send_group(8'h00, 8'hFF, 8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
  endtask

  // shortest lines: a line feed after every block, the last one included
  task automatic test_one_block_lines();
    write_line_length(6'd1);
    send_group(8'hFF, 8'hFE, 8'hFD, 1'b1);
    send_byte(8'h01, 1'b1);
  endtask

  task automatic test_wrap_off();
    write_line_length(6'd0);
    send_group(8'h3C, 8'hC3, 8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
  endtask

  // length changed while two bytes are held, taking effect on the next block
  task automatic test_midstream_write();
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    write_line_length(6'd1);
    send_byte(8'h56, 1'b1);
  endtask

  // length lowered below the running block count
  task automatic test_lowered_length();
    write_line_length(6'd63);
    send_group(8'h0F, 8'hF0, 8'h99, 1'b0);
    send_group(8'h66, 8'hC0, 8'h03, 1'b0);
    write_line_length(6'd1);
    send_byte(8'hE7, 1'b1);
  endtask

  // block count runs past 63 and wraps before meeting the lowered length
  task automatic test_count_wrap();
    set_idling(20, 20);
    write_line_length(6'd0);
    repeat (30) send_byte(char_t'($urandom_range(255)), 1'b0);
    write_line_length(6'd5);
    repeat (177) send_byte(char_t'($urandom_range(255)), 1'b0);
    send_byte(char_t'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_random_streams(input int n_bytes);
    int len;
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
      for (int i = 0; i < len && sent < n_bytes; i++) begin
        send_byte(char_t'($urandom_range(255)), i == len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_random_phases();
    set_idling(0, 0);
    write_line_length(6'd2);
    send_random_streams(30);
    set_idling(47, 0);
    write_line_length(6'($urandom_range(6, 1)));
    send_random_streams(30);
    set_idling(0, 47);
    write_line_length(6'd1);
    send_random_streams(30);
    set_idling(20, 20);
    write_line_length(6'($urandom_range(63)));
    send_random_streams(30);
  endtask

  // receiver side: random stalls, then check each accepted character
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    enc_char_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected character 0x%02h with nothing queued", out_bus.out_char);
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (want.code == CH_LF) line_feeds_seen++;
        if (out_bus.out_char !== want.code || out_bus.run_last !== want.run_last ||
            out_bus.stream_end !== want.stream_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("char %0d: expected 0x%02h last %0b end %0b, got 0x%02h last %0b end %0b",
                     chars_checked, want.code, want.run_last, want.stream_end,
                     out_bus.out_char, out_bus.run_last, out_bus.stream_end);
        end
      end
    end
  end

  initial begin
    clk                     = 1'b0;
    rst_n                   = 1'b0;
    in_bus.valid            = 1'b0;
    in_bus.in_byte          = '0;
    in_bus.final_byte       = 1'b0;
    out_bus.ready           = 1'b0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.blocks_per_line = '0;
    held                    = '0;
    held_cnt                = '0;
    blk_cnt                 = '0;
    line_len                = BPL_RESET;
    bytes_sent              = 0;
    chars_checked           = 0;
    line_feeds_seen         = 0;
    settings_used           = 0;
    mismatches              = 0;
    set_idling(0, 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_padding();
    test_one_block_lines();
    test_wrap_off();
    test_midstream_write();
    test_lowered_length();
    test_count_wrap();
    test_random_phases();

    quiesce();
    repeat (20) @(posedge clk);
    $display("covered %0d bytes, %0d characters (%0d line feeds) over %0d line lengths",
             bytes_sent, chars_checked, line_feeds_seen, settings_used);
    $display("idling patterns: none, sender 47%%, receiver 47%%, both 20%%");
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("base64_stream_encoder: match");
    end else begin
      $display("base64_stream_encoder: mismatch");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timed out with %0d characters still queued", pending_chars.size());
    $display("base64_stream_encoder: mismatch");
    $finish;
  end

endmodule
